// ===== rtl/pmd_pkg.sv =====
// ----------------------------------------------------------------------------
// pmd_pkg
// shared widths, register indexes and the microcode table of the pid step
// ----------------------------------------------------------------------------
package pmd_pkg;

    // field widths
    localparam int SETPOINT_W = 13;
    localparam int GAIN_W     = 14;
    localparam int OFFSET_W   = 10;
    localparam int PV_W       = 14;
    localparam int DRIVE_W    = 11;
    localparam int ERR_W      = 15;
    localparam int DIFF_W     = 16;
    localparam int INTEG_W    = 29;
    localparam int LIM_W      = 27;
    localparam int CMP_W      = INTEG_W + 1;
    localparam int PROD_W     = 44;
    localparam int MAG_W      = PROD_W - 1;
    localparam int PC_W       = 4;

    // port widths
    localparam int S_DATA_W   = 32;
    localparam int M_DATA_W   = 40;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;

    // largest drive magnitude
    localparam logic [DRIVE_W-2:0] MAG_MAX = 10'd1023;

    // configuration register indexes
    typedef logic [CFG_IDX_W-1:0] reg_idx_t;
    localparam reg_idx_t REG_SETPOINT     = 3'd0;
    localparam reg_idx_t REG_GAIN_P       = 3'd1;
    localparam reg_idx_t REG_GAIN_I       = 3'd2;
    localparam reg_idx_t REG_GAIN_D       = 3'd3;
    localparam reg_idx_t REG_PWM_OFFSET   = 3'd4;
    localparam reg_idx_t REG_GAIN_DIVISOR = 3'd5;
    localparam reg_idx_t REG_INTEGRAL_CAP = 3'd6;
    localparam reg_idx_t REG_DEAD_BAND    = 3'd7;

    // multiplier operand select
    typedef logic [2:0] mul_sel_t;
    localparam mul_sel_t MUL_NONE = 3'd0;
    localparam mul_sel_t MUL_LIM  = 3'd1;
    localparam mul_sel_t MUL_P    = 3'd2;
    localparam mul_sel_t MUL_D    = 3'd3;
    localparam mul_sel_t MUL_I    = 3'd4;

    // datapath operation
    typedef logic [3:0] op_t;
    localparam op_t OP_NOP     = 4'd0;
    localparam op_t OP_ERR     = 4'd1;
    localparam op_t OP_PREP    = 4'd2;
    localparam op_t OP_CLAMP   = 4'd3;
    localparam op_t OP_ACC     = 4'd4;
    localparam op_t OP_DIVLD   = 4'd5;
    localparam op_t OP_RUN_OUT = 4'd6;
    localparam op_t OP_MAN_OUT = 4'd7;

    // sequencing
    typedef logic [2:0] jmp_t;
    localparam jmp_t J_NEXT = 3'd0;
    localparam jmp_t J_WAIT = 3'd1;
    localparam jmp_t J_LOOP = 3'd2;
    localparam jmp_t J_EMIT = 3'd3;
    localparam jmp_t J_GO   = 3'd4;

    typedef logic [PC_W-1:0] pc_t;
    localparam pc_t STEP_IDLE      = 4'd0;
    localparam pc_t STEP_ERR       = 4'd1;
    localparam pc_t STEP_PREP      = 4'd2;
    localparam pc_t STEP_CLAMP     = 4'd3;
    localparam pc_t STEP_SUM_D     = 4'd4;
    localparam pc_t STEP_SUM_I     = 4'd5;
    localparam pc_t STEP_DIV_START = 4'd6;
    localparam pc_t STEP_DIV_LOOP  = 4'd7;
    localparam pc_t STEP_RUN_OUT   = 4'd8;
    localparam pc_t STEP_MAN_OUT   = 4'd9;

    typedef struct packed {
        mul_sel_t mul_sel;
        op_t      op;
        jmp_t     jmp;
        pc_t      target;
    } ctrl_t;

    // control store
    function automatic ctrl_t ucode(input pc_t pc);
        ctrl_t c;
        c = '{MUL_NONE, OP_NOP, J_GO, STEP_IDLE};
        case (pc)
            STEP_IDLE:      c = '{MUL_NONE, OP_NOP,     J_WAIT, STEP_MAN_OUT};
            STEP_ERR:       c = '{MUL_LIM,  OP_ERR,     J_NEXT, STEP_IDLE};
            STEP_PREP:      c = '{MUL_P,    OP_PREP,    J_NEXT, STEP_IDLE};
            STEP_CLAMP:     c = '{MUL_D,    OP_CLAMP,   J_NEXT, STEP_IDLE};
            STEP_SUM_D:     c = '{MUL_I,    OP_ACC,     J_NEXT, STEP_IDLE};
            STEP_SUM_I:     c = '{MUL_NONE, OP_ACC,     J_NEXT, STEP_IDLE};
            STEP_DIV_START: c = '{MUL_NONE, OP_DIVLD,   J_NEXT, STEP_IDLE};
            STEP_DIV_LOOP:  c = '{MUL_NONE, OP_NOP,     J_LOOP, STEP_IDLE};
            STEP_RUN_OUT:   c = '{MUL_NONE, OP_RUN_OUT, J_EMIT, STEP_IDLE};
            STEP_MAN_OUT:   c = '{MUL_NONE, OP_MAN_OUT, J_EMIT, STEP_IDLE};
            default:        c = '{MUL_NONE, OP_NOP,     J_GO,   STEP_IDLE};
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/pmd_div.sv =====
// ----------------------------------------------------------------------------
// pmd_div
// restoring divider for unsigned operands, one quotient bit per cycle
// ----------------------------------------------------------------------------
module pmd_div #(
    parameter int NUM_W = 43,
    parameter int DEN_W = 14
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             busy,
    output logic [NUM_W-1:0] quotient
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] rem_next;
    logic [NUM_W-1:0] quo_reg;
    logic [NUM_W-1:0] quo_next;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   trial;
    logic             ge;

    assign busy     = (cnt_reg != '0);
    assign quotient = quo_reg;

    // one trial subtraction per step
    assign shifted = {rem_reg, quo_reg[NUM_W-1]};
    assign ge      = (shifted >= {1'b0, den_reg});
    assign trial   = shifted - {1'b0, den_reg};

    always_comb
    begin
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        if (start)
        begin
            cnt_next = CNT_W'(NUM_W);
            rem_next = '0;
            quo_next = dividend;
        end
        else if (busy)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
            rem_next = ge ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            den_reg <= divisor;
        end
    end

endmodule

// ===== rtl/pid_motor_drive_step.sv =====
// ----------------------------------------------------------------------------
// pid_motor_drive_step
// run tick: the error, prep, clamp and sum steps, the 43 step bit-serial divider
// and the output step; manual or stop tick: straight to the output step
// a new input word is taken only once the last result is in the output register
// reset clears the registers to their defaults, the integral, the last error
// and the held direction; no clearing pass, input is taken right after reset
// ----------------------------------------------------------------------------
// pid position/speed loop step with integral clamp, deadband and pwm offset.
// a small control store sequences one shared 15x29 multiplier, an adder and
// an iterative divider through the run computation.
// ----------------------------------------------------------------------------
module pid_motor_drive_step (
    input  logic                             clk,
    input  logic                             rst_n,
    // input word
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [13:0] process_value, [14] run_enable, [15] manual_enable,
    // [26:16] manual_drive, [31:27] zero
    input  logic [pmd_pkg::S_DATA_W-1:0]     s_tdata,
    // result word
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [10:0] drive, [11] motor_direction, [22:12] pwm_duty,
    // [37:23] control_error, [39:38] zero
    output logic [pmd_pkg::M_DATA_W-1:0]     m_tdata,
    // configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [pmd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pmd_pkg::CFG_DATA_W-1:0]   cfg_data
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [pmd_pkg::SETPOINT_W-1:0] setpoint_reg;
    logic [pmd_pkg::GAIN_W-1:0]     gain_p_reg;
    logic [pmd_pkg::GAIN_W-1:0]     gain_i_reg;
    logic [pmd_pkg::GAIN_W-1:0]     gain_d_reg;
    logic [pmd_pkg::OFFSET_W-1:0]   pwm_offset_reg;
    logic [pmd_pkg::GAIN_W-1:0]     gain_divisor_reg;
    logic [pmd_pkg::GAIN_W-1:0]     integral_cap_reg;
    logic [pmd_pkg::GAIN_W-1:0]     dead_band_reg;

    // always ready for a register write
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setpoint_reg     <= 13'd512;
            gain_p_reg       <= 14'd120;
            gain_i_reg       <= '0;
            gain_d_reg       <= '0;
            pwm_offset_reg   <= '0;
            gain_divisor_reg <= 14'd100;
            integral_cap_reg <= 14'd100;
            dead_band_reg    <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                pmd_pkg::REG_SETPOINT:     setpoint_reg <= cfg_data[pmd_pkg::SETPOINT_W-1:0];
                pmd_pkg::REG_GAIN_P:       gain_p_reg <= cfg_data;
                pmd_pkg::REG_GAIN_I:       gain_i_reg <= cfg_data;
                pmd_pkg::REG_GAIN_D:       gain_d_reg <= cfg_data;
                pmd_pkg::REG_PWM_OFFSET:   pwm_offset_reg <= cfg_data[pmd_pkg::OFFSET_W-1:0];
                pmd_pkg::REG_GAIN_DIVISOR: gain_divisor_reg <= cfg_data;
                pmd_pkg::REG_INTEGRAL_CAP: integral_cap_reg <= cfg_data;
                pmd_pkg::REG_DEAD_BAND:    dead_band_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // sequencer: program counter and the control word it selects
    // ------------------------------------------------------------------
    pmd_pkg::pc_t   pc_reg;
    pmd_pkg::pc_t   pc_next;
    pmd_pkg::ctrl_t ctrl;
    logic           div_busy;
    logic           emit_fire;
    logic           in_run;

    assign ctrl      = pmd_pkg::ucode(pc_reg);
    assign s_tready  = (pc_reg == pmd_pkg::STEP_IDLE);
    assign in_run    = s_tdata[14];
    // a result leaves only into a free (or draining) output register
    assign emit_fire = (ctrl.jmp == pmd_pkg::J_EMIT) && (!m_tvalid || m_tready);

    always_comb
    begin
        pc_next = pc_reg;
        case (ctrl.jmp)
            pmd_pkg::J_NEXT: pc_next = pc_reg + pmd_pkg::PC_W'(1);
            pmd_pkg::J_WAIT:
            begin
                // run ticks go through the loop program, the rest straight out
                if (s_tvalid)
                begin
                    pc_next = in_run ? pc_reg + pmd_pkg::PC_W'(1) : ctrl.target;
                end
            end
            pmd_pkg::J_LOOP:
            begin
                if (!div_busy)
                begin
                    pc_next = pc_reg + pmd_pkg::PC_W'(1);
                end
            end
            pmd_pkg::J_EMIT:
            begin
                if (emit_fire)
                begin
                    pc_next = ctrl.target;
                end
            end
            pmd_pkg::J_GO:   pc_next = ctrl.target;
            default:         pc_next = pmd_pkg::STEP_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // datapath registers
    // ------------------------------------------------------------------
    logic signed [pmd_pkg::PV_W-1:0]     pv_reg;
    logic                                manual_reg;
    logic signed [pmd_pkg::DRIVE_W-1:0]  mdrive_reg;
    logic signed [pmd_pkg::ERR_W-1:0]    err_reg;
    logic signed [pmd_pkg::DIFF_W-1:0]   diff_reg;
    logic signed [pmd_pkg::INTEG_W-1:0]  acc_reg;
    logic        [pmd_pkg::LIM_W-1:0]    lim_reg;
    logic signed [pmd_pkg::PROD_W-1:0]   prod_reg;
    logic signed [pmd_pkg::PROD_W-1:0]   sum_reg;
    logic                                neg_reg;

    // loop state
    logic signed [pmd_pkg::INTEG_W-1:0]  integral_reg;
    logic signed [pmd_pkg::ERR_W-1:0]    prev_err_reg;
    logic                                direction_reg;

    // result word
    logic signed [pmd_pkg::DRIVE_W-1:0]  out_drive_reg;
    logic                                out_dir_reg;
    logic        [pmd_pkg::DRIVE_W-1:0]  out_pwm_reg;
    logic signed [pmd_pkg::ERR_W-1:0]    out_err_reg;
    logic                                out_valid_reg;
    logic                                out_valid_next;

    // ------------------------------------------------------------------
    // shared multiplier, registered
    // ------------------------------------------------------------------
    logic        [pmd_pkg::GAIN_W-1:0]   mul_a;
    logic signed [pmd_pkg::INTEG_W-1:0]  mul_b;
    logic signed [pmd_pkg::GAIN_W:0]     mul_a_s;
    logic signed [pmd_pkg::PROD_W-1:0]   mul_full;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (ctrl.mul_sel)
            pmd_pkg::MUL_LIM:
            begin
                mul_a = integral_cap_reg;
                mul_b = {{(pmd_pkg::INTEG_W - pmd_pkg::GAIN_W){1'b0}}, gain_i_reg};
            end
            pmd_pkg::MUL_P:
            begin
                mul_a = gain_p_reg;
                mul_b = {{(pmd_pkg::INTEG_W - pmd_pkg::ERR_W){err_reg[pmd_pkg::ERR_W-1]}},
                         err_reg};
            end
            pmd_pkg::MUL_D:
            begin
                mul_a = gain_d_reg;
                mul_b = {{(pmd_pkg::INTEG_W - pmd_pkg::DIFF_W){diff_reg[pmd_pkg::DIFF_W-1]}},
                         diff_reg};
            end
            pmd_pkg::MUL_I:
            begin
                mul_a = gain_i_reg;
                mul_b = integral_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_a_s  = $signed({1'b0, mul_a});
    assign mul_full = mul_a_s * mul_b;

    // ------------------------------------------------------------------
    // error, derivative and integral clamp
    // ------------------------------------------------------------------
    logic signed [pmd_pkg::ERR_W-1:0]   err_new;
    logic signed [pmd_pkg::DIFF_W-1:0]  diff_new;
    logic signed [pmd_pkg::INTEG_W-1:0] acc_new;
    logic signed [pmd_pkg::CMP_W-1:0]   acc_ext;
    logic signed [pmd_pkg::CMP_W-1:0]   integ_ext;
    logic signed [pmd_pkg::CMP_W-1:0]   lim_pos;
    logic signed [pmd_pkg::CMP_W-1:0]   lim_neg;
    logic signed [pmd_pkg::CMP_W-1:0]   clamp_ext;

    assign err_new  = $signed({{(pmd_pkg::ERR_W - pmd_pkg::SETPOINT_W){1'b0}}, setpoint_reg})
                    - $signed({pv_reg[pmd_pkg::PV_W-1], pv_reg});
    assign diff_new = $signed({err_reg[pmd_pkg::ERR_W-1], err_reg})
                    - $signed({prev_err_reg[pmd_pkg::ERR_W-1], prev_err_reg});
    assign acc_new  = integral_reg
                    + $signed({{(pmd_pkg::INTEG_W - pmd_pkg::ERR_W){err_reg[pmd_pkg::ERR_W-1]}},
                               err_reg});

    assign acc_ext   = $signed({acc_reg[pmd_pkg::INTEG_W-1], acc_reg});
    assign integ_ext = $signed({integral_reg[pmd_pkg::INTEG_W-1], integral_reg});
    assign lim_pos   = $signed({{(pmd_pkg::CMP_W - pmd_pkg::LIM_W){1'b0}}, lim_reg});
    assign lim_neg   = -lim_pos;

    // anti-windup: the integral sum is pulled inside +/- limit after the error is added
    always_comb
    begin
        if (acc_ext > lim_pos)
        begin
            clamp_ext = lim_pos;
        end
        else if (acc_ext < lim_neg)
        begin
            clamp_ext = lim_neg;
        end
        else
        begin
            clamp_ext = acc_ext;
        end
    end

    // ------------------------------------------------------------------
    // divider on the magnitude of the weighted sum
    // ------------------------------------------------------------------
    logic                              div_start;
    logic [pmd_pkg::MAG_W-1:0]         sum_mag;
    logic [pmd_pkg::PROD_W-1:0]        sum_neg;
    logic [pmd_pkg::GAIN_W-1:0]        divisor;
    logic [pmd_pkg::MAG_W-1:0]         quotient;

    assign div_start = (ctrl.op == pmd_pkg::OP_DIVLD);
    assign sum_neg   = -sum_reg;
    assign sum_mag   = sum_reg[pmd_pkg::PROD_W-1] ? sum_neg[pmd_pkg::MAG_W-1:0]
                                                  : sum_reg[pmd_pkg::MAG_W-1:0];
    // a divisor of zero counts as one
    assign divisor   = (gain_divisor_reg == '0) ? pmd_pkg::GAIN_W'(1) : gain_divisor_reg;

    pmd_div #(
        .NUM_W (pmd_pkg::MAG_W),
        .DEN_W (pmd_pkg::GAIN_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_mag),
        .divisor  (divisor),
        .busy     (div_busy),
        .quotient (quotient)
    );

    // ------------------------------------------------------------------
    // result forming
    // ------------------------------------------------------------------
    logic [pmd_pkg::DRIVE_W-2:0]         q_sat;
    logic [pmd_pkg::ERR_W-1:0]           err_neg;
    logic [pmd_pkg::ERR_W-1:0]           err_mag;
    logic signed [pmd_pkg::DRIVE_W-1:0]  md_sat;
    logic [pmd_pkg::DRIVE_W-1:0]         md_neg;
    logic signed [pmd_pkg::DRIVE_W-1:0]  res_drive;
    logic                                res_dir;
    logic [pmd_pkg::DRIVE_W-1:0]         res_pwm;

    // quotient saturates to full scale; the sign was kept aside
    assign q_sat   = (|quotient[pmd_pkg::MAG_W-1:pmd_pkg::DRIVE_W-1]) ? pmd_pkg::MAG_MAX
                                                                       : quotient[pmd_pkg::DRIVE_W-2:0];
    assign err_neg = -err_reg;
    assign err_mag = err_reg[pmd_pkg::ERR_W-1] ? err_neg : err_reg;
    // manual most negative code is pulled in to -full scale
    assign md_sat  = (mdrive_reg == {1'b1, {(pmd_pkg::DRIVE_W-1){1'b0}}})
                   ? -$signed({1'b0, pmd_pkg::MAG_MAX}) : mdrive_reg;
    assign md_neg  = -md_sat;

    always_comb
    begin
        res_drive = '0;
        res_dir   = direction_reg;
        res_pwm   = '0;
        if (ctrl.op == pmd_pkg::OP_RUN_OUT)
        begin
            res_drive = neg_reg ? -$signed({1'b0, q_sat}) : $signed({1'b0, q_sat});
            res_dir   = !(neg_reg && (q_sat != '0));
            if (err_mag > {{(pmd_pkg::ERR_W - pmd_pkg::GAIN_W){1'b0}}, dead_band_reg})
            begin
                res_pwm = {1'b0, q_sat} + {1'b0, pwm_offset_reg};
            end
        end
        else if (manual_reg)
        begin
            res_drive = md_sat;
            res_dir   = !md_sat[pmd_pkg::DRIVE_W-1] && (md_sat != '0);
            res_pwm   = md_sat[pmd_pkg::DRIVE_W-1] ? md_neg : md_sat;
        end
    end

    // ------------------------------------------------------------------
    // control and state registers
    // ------------------------------------------------------------------
    assign out_valid_next = emit_fire || (out_valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= pmd_pkg::STEP_IDLE;
            out_valid_reg <= 1'b0;
            integral_reg  <= '0;
            prev_err_reg  <= '0;
            direction_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
            if (ctrl.op == pmd_pkg::OP_CLAMP)
            begin
                integral_reg <= clamp_ext[pmd_pkg::INTEG_W-1:0];
                prev_err_reg <= err_reg;
            end
            if (emit_fire)
            begin
                direction_reg <= res_dir;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            pv_reg     <= s_tdata[13:0];
            manual_reg <= s_tdata[15];
            mdrive_reg <= s_tdata[26:16];
        end
        if (ctrl.mul_sel != pmd_pkg::MUL_NONE)
        begin
            prod_reg <= mul_full;
        end
        case (ctrl.op)
            pmd_pkg::OP_ERR:
            begin
                err_reg <= err_new;
            end
            pmd_pkg::OP_PREP:
            begin
                lim_reg  <= prod_reg[pmd_pkg::LIM_W-1:0];
                acc_reg  <= acc_new;
                diff_reg <= diff_new;
            end
            pmd_pkg::OP_CLAMP:
            begin
                sum_reg <= prod_reg;
            end
            pmd_pkg::OP_ACC:
            begin
                sum_reg <= sum_reg + prod_reg;
            end
            pmd_pkg::OP_DIVLD:
            begin
                neg_reg <= sum_reg[pmd_pkg::PROD_W-1];
            end
            default:
            begin
            end
        endcase
        if (emit_fire)
        begin
            out_drive_reg <= res_drive;
            out_dir_reg   <= res_dir;
            out_pwm_reg   <= res_pwm;
            out_err_reg   <= prev_err_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_err_reg, out_pwm_reg, out_dir_reg, out_drive_reg};

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (pc_reg != pmd_pkg::STEP_IDLE))
        else $error("sequencer stayed idle after taking a word");

    a_integral_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == pmd_pkg::STEP_DIV_LOOP) |-> ((integ_ext <= lim_pos) && (integ_ext >= lim_neg)))
        else $error("integral outside its clamp");

    a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(ctrl.jmp == pmd_pkg::J_EMIT))
        else $error("result word raised outside an output step");

    a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_drive_reg != {1'b1, {(pmd_pkg::DRIVE_W-1){1'b0}}}))
        else $error("drive beyond full scale");

    a_div_started: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == pmd_pkg::STEP_DIV_START) |=> div_busy)
        else $error("divider did not start");

endmodule
